// ===== design/pswf_pkg.sv =====
`default_nettype none
package pswf_pkg;

   localparam int TIME_W  = 32;
   localparam int LEVEL_W = 24;
   // ramp magnitude |high - low| needs one bit more than a level
   localparam int MAG_W   = LEVEL_W + 1;
   localparam int PROD_W  = MAG_W + TIME_W;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_LEVEL   = 3'd0,
      CSR_HIGH_LEVEL  = 3'd1,
      CSR_DELAY_TIME  = 3'd2,
      CSR_RISE_TIME   = 3'd3,
      CSR_FALL_TIME   = 3'd4,
      CSR_WIDTH_TIME  = 3'd5,
      CSR_PERIOD_TIME = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_DELAY   = 3'd0,
      PH_RISING  = 3'd1,
      PH_HIGH    = 3'd2,
      PH_FALLING = 3'd3,
      PH_LOW     = 3'd4
   } phase_type;

   typedef struct packed {
      phase_type                  phase;
      logic signed [LEVEL_W-1:0]  from;
      logic                       neg;
   } ramp_side_type;

endpackage
`default_nettype wire

// ===== design/pswf_mod_pipe.sv =====
`default_nettype none
module pswf_mod_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [pswf_pkg::TIME_W-1:0]   in_dividend,
   input  logic [pswf_pkg::TIME_W-1:0]   in_divisor,
   input  logic                          in_pre,
   output logic                          out_valid,
   output logic [pswf_pkg::TIME_W-1:0]   out_rem,
   output logic                          out_pre
);
   import pswf_pkg::*;

   // zero period means no wrap: treat it as 2^TIME_W
   logic [TIME_W:0]   div_ext;
   logic [TIME_W-1:0] rem_st [TIME_W+1];
   logic [TIME_W-1:0] dvd_st [TIME_W+1];
   logic              val_st [TIME_W+1];
   logic              pre_st [TIME_W+1];

   assign div_ext   = {(in_divisor == '0), in_divisor};
   assign rem_st[0] = '0;
   assign dvd_st[0] = in_dividend;
   assign val_st[0] = in_valid;
   assign pre_st[0] = in_pre;

   for (genvar k = 0; k < TIME_W; k++) begin : g_step
      logic [TIME_W:0]   trial;
      logic [TIME_W-1:0] rem_ff, dvd_ff;
      logic              valid_ff, pre_ff;

      assign trial = {rem_st[k], dvd_st[k][TIME_W-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= val_st[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (trial >= div_ext) begin
               rem_ff <= TIME_W'(trial - div_ext);
            end else begin
               rem_ff <= trial[TIME_W-1:0];
            end
            dvd_ff <= dvd_st[k] << 1;
            pre_ff <= pre_st[k];
         end
      end

      assign rem_st[k+1] = rem_ff;
      assign dvd_st[k+1] = dvd_ff;
      assign val_st[k+1] = valid_ff;
      assign pre_st[k+1] = pre_ff;
   end

   assign out_valid = val_st[TIME_W];
   assign out_rem   = rem_st[TIME_W];
   assign out_pre   = pre_st[TIME_W];

endmodule
`default_nettype wire

// ===== design/pswf_ramp_div.sv =====
`default_nettype none
module pswf_ramp_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          adv,
   input  logic                          in_valid,
   input  logic [pswf_pkg::PROD_W-1:0]   in_prod,
   input  logic [pswf_pkg::TIME_W-1:0]   in_den,
   input  pswf_pkg::ramp_side_type       in_side,
   output logic                          out_valid,
   output logic [pswf_pkg::MAG_W-1:0]    out_quo,
   output pswf_pkg::ramp_side_type       out_side
);
   import pswf_pkg::*;

   // prod < mag * den, so the top TIME_W bits already sit below den
   logic [TIME_W-1:0] rem_st [MAG_W+1];
   logic [TIME_W-1:0] den_st [MAG_W+1];
   logic [MAG_W-1:0]  low_st [MAG_W+1];
   logic [MAG_W-1:0]  quo_st [MAG_W+1];
   logic              val_st [MAG_W+1];
   ramp_side_type     side_st [MAG_W+1];

   assign rem_st[0]  = in_prod[PROD_W-1:MAG_W];
   assign low_st[0]  = in_prod[MAG_W-1:0];
   assign den_st[0]  = in_den;
   assign quo_st[0]  = '0;
   assign val_st[0]  = in_valid;
   assign side_st[0] = in_side;

   for (genvar k = 0; k < MAG_W; k++) begin : g_step
      logic [TIME_W:0]   trial;
      logic              take;
      logic [TIME_W-1:0] rem_ff, den_ff;
      logic [MAG_W-1:0]  low_ff, quo_ff;
      logic              valid_ff;
      ramp_side_type     side_ff;

      assign trial = {rem_st[k], low_st[k][MAG_W-1]};
      assign take  = (trial >= {1'b0, den_st[k]});

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= val_st[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            if (take) begin
               rem_ff <= TIME_W'(trial - {1'b0, den_st[k]});
            end else begin
               rem_ff <= trial[TIME_W-1:0];
            end
            low_ff  <= low_st[k] << 1;
            quo_ff  <= {quo_st[k][MAG_W-2:0], take};
            den_ff  <= den_st[k];
            side_ff <= side_st[k];
         end
      end

      assign rem_st[k+1]  = rem_ff;
      assign low_st[k+1]  = low_ff;
      assign quo_st[k+1]  = quo_ff;
      assign den_st[k+1]  = den_ff;
      assign val_st[k+1]  = valid_ff;
      assign side_st[k+1] = side_ff;
   end

   assign out_valid = val_st[MAG_W];
   assign out_quo   = quo_st[MAG_W];
   assign out_side  = side_st[MAG_W];

endmodule
`default_nettype wire

// ===== design/pulse_source_waveform_core.sv =====
`default_nettype none
// PULSE waveform source: one time sample in, one level and phase out. Accepts a
// request every clock unless stalled. A bit-per-stage modulo pipeline over the period
// feeds a phase select register and a product register, then the bit-per-stage
// divider that scales the ramp, then the output register. The whole pipeline stalls
// together while a finished result waits on rsp_ready. Registers must only be
// written while no request is in flight.
module pulse_source_waveform_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pswf_pkg::TIME_W-1:0]           req_sample_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pswf_pkg::LEVEL_W-1:0]   rsp_level,
   output logic [2:0]                            rsp_phase,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pswf_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pswf_pkg::TIME_W-1:0]           csr_data
);
   import pswf_pkg::*;

   logic signed [LEVEL_W-1:0] low_ff, high_ff;
   logic [TIME_W-1:0] delay_ff, rise_ff, fall_ff, width_ff, period_ff;

   logic adv;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff    <= '0;
         high_ff   <= '0;
         delay_ff  <= '0;
         rise_ff   <= '0;
         fall_ff   <= '0;
         width_ff  <= '0;
         period_ff <= TIME_W'(1);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LOW_LEVEL:   low_ff    <= csr_data[LEVEL_W-1:0];
            CSR_HIGH_LEVEL:  high_ff   <= csr_data[LEVEL_W-1:0];
            CSR_DELAY_TIME:  delay_ff  <= csr_data;
            CSR_RISE_TIME:   rise_ff   <= csr_data;
            CSR_FALL_TIME:   fall_ff   <= csr_data;
            CSR_WIDTH_TIME:  width_ff  <= csr_data;
            CSR_PERIOD_TIME: period_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // modulo over the period
   logic              m_valid, m_pre;
   logic [TIME_W-1:0] m_rem;

   pswf_mod_pipe u_mod (
      .clock       (clock),
      .reset       (reset),
      .adv         (adv),
      .in_valid    (req_valid),
      .in_dividend (TIME_W'(req_sample_time - delay_ff)),
      .in_divisor  (period_ff),
      .in_pre      (req_sample_time < delay_ff),
      .out_valid   (m_valid),
      .out_rem     (m_rem),
      .out_pre     (m_pre)
   );

   // phase select
   logic [TIME_W:0]   rw_end;
   logic [TIME_W+1:0] rwf_end;
   logic signed [MAG_W-1:0] up_diff;
   logic [MAG_W-1:0]  up_mag;
   logic              up_neg;
   ramp_side_type     side_in;
   logic [MAG_W-1:0]  mag_in;
   logic [TIME_W-1:0] num_in, den_in;

   assign rw_end  = {1'b0, rise_ff} + {1'b0, width_ff};
   assign rwf_end = {1'b0, rw_end} + {2'b00, fall_ff};
   assign up_diff = MAG_W'(high_ff) - MAG_W'(low_ff);
   assign up_neg  = up_diff[MAG_W-1];
   assign up_mag  = up_neg ? MAG_W'(-up_diff) : up_diff;

   always_comb begin
      side_in = '{phase: PH_LOW, from: low_ff, neg: 1'b0};
      mag_in  = '0;
      num_in  = '0;
      den_in  = TIME_W'(1);
      priority if (m_pre) begin
         side_in.phase = PH_DELAY;
      end else if (m_rem < rise_ff) begin
         side_in = '{phase: PH_RISING, from: low_ff, neg: up_neg};
         mag_in  = up_mag;
         num_in  = m_rem;
         den_in  = rise_ff;
      end else if ({1'b0, m_rem} < rw_end) begin
         side_in.phase = PH_HIGH;
         side_in.from  = high_ff;
      end else if ({2'b00, m_rem} < rwf_end) begin
         side_in = '{phase: PH_FALLING, from: high_ff, neg: !up_neg && (up_mag != '0)};
         mag_in  = up_mag;
         num_in  = TIME_W'({1'b0, m_rem} - rw_end);
         den_in  = fall_ff;
      end else begin
         side_in.phase = PH_LOW;
      end
   end

   logic              p_valid_ff;
   ramp_side_type     p_side_ff;
   logic [MAG_W-1:0]  p_mag_ff;
   logic [TIME_W-1:0] p_num_ff, p_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff <= 1'b0;
      end else if (adv) begin
         p_valid_ff <= m_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_side_ff <= side_in;
         p_mag_ff  <= mag_in;
         p_num_ff  <= num_in;
         p_den_ff  <= den_in;
      end
   end

   // product stage
   logic              x_valid_ff;
   ramp_side_type     x_side_ff;
   logic [PROD_W-1:0] x_prod_ff;
   logic [TIME_W-1:0] x_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_valid_ff <= 1'b0;
      end else if (adv) begin
         x_valid_ff <= p_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_side_ff <= p_side_ff;
         x_prod_ff <= PROD_W'(p_mag_ff) * PROD_W'(p_num_ff);
         x_den_ff  <= p_den_ff;
      end
   end

   logic             d_valid;
   logic [MAG_W-1:0] d_quo;
   ramp_side_type    d_side;

   pswf_ramp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (x_valid_ff),
      .in_prod   (x_prod_ff),
      .in_den    (x_den_ff),
      .in_side   (x_side_ff),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   // output register
   logic signed [LEVEL_W-1:0] level_in, level_ff;
   logic [2:0]                phase_ff;
   logic [MAG_W-1:0]          from_ext;

   assign from_ext = MAG_W'(d_side.from);
   assign level_in = d_side.neg ? LEVEL_W'(from_ext - d_quo) : LEVEL_W'(from_ext + d_quo);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         level_ff <= level_in;
         phase_ff <= d_side.phase;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_level = level_ff;
   assign rsp_phase = phase_ff;

`ifndef SYNTHESIS
   a_high_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_phase == PH_HIGH) |-> rsp_level == high_ff)
      else $error("high phase level mismatch");
   a_rest_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_phase == PH_DELAY) || (rsp_phase == PH_LOW)) |-> rsp_level == low_ff)
      else $error("resting level mismatch");
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");
`endif

endmodule
`default_nettype wire
